### rtl/core/nbfr_pkg.sv
package nbfr_pkg;

	localparam int unsigned WORD_W = 9;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned MS_W   = 16;

	localparam logic [WORD_W-1:0] ADDR_FLAG = 9'h100;
	localparam logic [BYTE_W-1:0] SUM_START = 8'h00;

	localparam logic MODE_WORD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADCMD  = 2'd1;
	localparam logic [1:0] ST_BADSUM  = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	localparam logic [1:0] REG_OWN_ADDR = 2'd0;
	localparam logic [1:0] REG_EXP_CMD  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	localparam logic [MS_W-1:0] TIMEOUT_RESET = 16'd10;

	typedef struct packed {
		logic [BYTE_W-1:0] own_address;
		logic [BYTE_W-1:0] expected_command;
		logic [MS_W-1:0]   timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] byte_index;
		logic [1:0]        status;
		logic              last;
	} res_t;

endpackage

### rtl/core/nbfr_regs.sv
module nbfr_regs
	import nbfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address      <= '0;
			cfg_q.expected_command <= '0;
			cfg_q.timeout_ms       <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_OWN_ADDR: cfg_q.own_address      <= pwdata[BYTE_W-1:0];
				REG_EXP_CMD:  cfg_q.expected_command <= pwdata[BYTE_W-1:0];
				REG_TIMEOUT:  cfg_q.timeout_ms       <= pwdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OWN_ADDR: prdata = {24'd0, cfg_q.own_address};
			REG_EXP_CMD:  prdata = {24'd0, cfg_q.expected_command};
			REG_TIMEOUT:  prdata = {16'd0, cfg_q.timeout_ms};
			default:      prdata = '0;
		endcase
	end

endmodule

### rtl/core/nbfr_engine.sv
module nbfr_engine
	import nbfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_mode,
	input  logic [WORD_W-1:0] in_word,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_CSUM = 3'd4
	} phase_t;

	logic              valid_s1;
	logic              mode_s1;
	logic [WORD_W-1:0] word_s1;

	phase_t            phase_q,  phase_d;
	logic [BYTE_W-1:0] sum_q,    sum_d;
	logic [BYTE_W-1:0] left_q,   left_d;
	logic [BYTE_W-1:0] index_q,  index_d;
	logic [MS_W-1:0]   idle_q,   idle_d;

	logic              take;
	logic              close;
	logic [1:0]        close_st;
	logic [BYTE_W-1:0] low;
	logic [BYTE_W-1:0] sum_add;
	logic [BYTE_W-1:0] left_dec;

	assign take     = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || res_ready;
	assign low      = word_s1[BYTE_W-1:0];
	assign sum_add  = sum_q + low;
	assign left_dec = left_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= in_mode;
			word_s1 <= in_word;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		left_d   = left_q;
		index_d  = index_q;
		idle_d   = idle_q;
		close    = 1'b0;
		close_st = ST_OK;
		res      = '0;
		res_valid = 1'b0;

		if (mode_s1 == MODE_TICK) begin
			if (idle_q >= cfg.timeout_ms) begin
				close    = 1'b1;
				close_st = ST_TIMEOUT;
			end else begin
				idle_d = idle_q + 16'd1;
			end
		end else begin
			unique case (phase_q)
				PH_CMD: begin
					if (word_s1 != {1'b0, cfg.expected_command}) begin
						close    = 1'b1;
						close_st = ST_BADCMD;
					end else begin
						sum_d   = low;
						idle_d  = '0;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					sum_d   = sum_add;
					idle_d  = '0;
					left_d  = low;
					index_d = '0;
					phase_d = (low == '0) ? PH_CSUM : PH_DATA;
				end
				PH_DATA: begin
					res_valid      = 1'b1;
					res.kind       = KIND_DATA;
					res.data_byte  = low;
					res.byte_index = index_q;
					sum_d   = sum_add;
					idle_d  = '0;
					index_d = index_q + 8'd1;
					left_d  = left_dec;
					if (left_dec == '0) begin
						phase_d = PH_CSUM;
					end
				end
				PH_CSUM: begin
					close    = 1'b1;
					close_st = (word_s1 == {1'b0, sum_q}) ? ST_OK : ST_BADSUM;
				end
				default: begin
					phase_d = PH_HUNT;
					if (word_s1 == (ADDR_FLAG | {1'b0, cfg.own_address})) begin
						phase_d = PH_CMD;
						sum_d   = SUM_START;
						idle_d  = '0;
					end
				end
			endcase
		end

		if (close) begin
			res_valid  = 1'b1;
			res        = '0;
			res.kind   = KIND_STATUS;
			res.status = close_st;
			res.last   = 1'b1;
			phase_d    = PH_HUNT;
			sum_d      = SUM_START;
			left_d     = '0;
			index_d    = '0;
			idle_d     = '0;
		end

		// the result only counts while stage 1 holds a valid item
		res_valid = res_valid && valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= SUM_START;
			left_q  <= '0;
			index_q <= '0;
			idle_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			left_q  <= left_d;
			index_q <= index_d;
			idle_q  <= idle_d;
		end
	end

endmodule

### rtl/core/nbfr_out.sv
module nbfr_out
	import nbfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	output logic res_ready,
	input  res_t res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic out_valid_q;
	res_t out_res_q;

	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

endmodule

### rtl/core/nine_bit_frame_receiver_top.sv
// channel  | dir | handshake        | content
// ---------+-----+------------------+-----------------------------------------------
// s_axis   | in  | tvalid / tready  | tuser: mode; tdata: word
// m_axis   | out | tvalid / tready  | tuser: kind; tlast: last;
//          |     |                  | tdata: data_byte, byte_index, status
// apb      | in  | psel/penable     | own_address @0, expected_command @4, timeout @8
//
// One item per clock sustained while m_axis does not stall: input register, frame logic,
// result register. A result passes from the input register through the frame logic
// into the result register and shows on m_axis from there.
// arst_n clears the frame state to hunting and the registers to their reset values.
// A stalled m_axis holds its result. Stage 1 then holds its item too, with or without a
// result, so s_tready drops whenever stage 1 is full behind a full, untaken output.
module nine_bit_frame_receiver_top
	import nbfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [8:0] word
	input  logic        s_tuser,   // [0] mode

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index, [17:16] status
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic res_valid;
	logic res_ready;

	nbfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nbfr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_word   (s_tdata[WORD_W-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	nbfr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'd0, out_res.status, out_res.byte_index, out_res.data_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule
